// ===== hw/rtl/hdlc_bit_deframer_fcs16_core_defines.svh =====
// Assertion macros for the HDLC deframer RTL files.
`ifndef HDLC_BIT_DEFRAMER_FCS16_CORE_DEFINES_SVH
`define HDLC_BIT_DEFRAMER_FCS16_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HDLC_DF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HDLC_DF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/hdlc_df_pkg.sv =====
// Types, constants and the CRC function of the HDLC deframer.
package hdlc_df_pkg;

  localparam int unsigned MaxFrameBytes = 1024;
  localparam int unsigned LenW          = 11;

  localparam logic [7:0]  FlagPattern  = 8'h7E;
  localparam logic [15:0] CrcPoly      = 16'h8408;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcResidue   = 16'hF0B8;
  localparam logic [7:0]  MinFrameRst  = 8'd6;
  localparam logic [2:0]  StuffRun     = 3'd5;
  localparam logic [2:0]  AbortRun     = 3'd6;
  localparam logic [LenW-1:0] MaxCount = LenW'(MaxFrameBytes);

  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindGood    = 2'd1,
    KindBad     = 2'd2,
    KindDiscard = 2'd3
  } kind_e;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
  } result_t;

  // Reflected CRC-16 over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] byte_in);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, byte_in};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== hw/rtl/hdlc_df_in_reg.sv =====
// Input register stage holding one received bit item.
module hdlc_df_in_reg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic bit_in_i,
  input  logic take_i,
  output logic valid_o,
  output logic bit_o
);

  logic valid_q, valid_d;
  logic bit_q, bit_d;

  // The stage frees up in the same cycle its item moves on.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    bit_d   = bit_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      bit_d   = bit_in_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign valid_o = valid_q;
  assign bit_o   = bit_q;

endmodule

// ===== hw/rtl/hdlc_df_proc.sv =====
// Deframer state: flag search, bit destuffing, byte assembly and FCS check.
`include "hdlc_bit_deframer_fcs16_core_defines.svh"

module hdlc_df_proc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      bit_i,
  input  logic [7:0]                min_frame_i,
  output hdlc_df_pkg::result_t      res_o
);

  logic [7:0]                  win_q, win_d;
  logic                        in_frame_q, in_frame_d;
  logic [2:0]                  ones_q, ones_d;
  logic [2:0]                  pos_q, pos_d;
  logic [hdlc_df_pkg::LenW-1:0] cnt_q, cnt_d;
  logic [7:0]                  part_q, part_d;
  logic [15:0]                 crc_q, crc_d;
  logic [7:0]                  part_new;
  logic [7:0]                  win_new;
  hdlc_df_pkg::result_t        res;

  always_comb begin
    win_new    = {bit_i, win_q[7:1]};
    part_new   = part_q | ({7'd0, bit_i} << pos_q);
    win_d      = win_q;
    in_frame_d = in_frame_q;
    ones_d     = ones_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    part_d     = part_q;
    crc_d      = crc_q;
    res.valid  = 1'b0;
    res.kind   = hdlc_df_pkg::KindData;
    res.data   = 8'd0;
    res.len    = '0;

    if (en_i) begin
      win_d = win_new;
      if (win_new == hdlc_df_pkg::FlagPattern) begin
        if (in_frame_q && (cnt_q != '0)) begin
          res.valid = 1'b1;
          res.len   = cnt_q;
          if (cnt_q < {3'd0, min_frame_i}) begin
            res.kind = hdlc_df_pkg::KindDiscard;
          end else if (crc_q == hdlc_df_pkg::CrcResidue) begin
            res.kind = hdlc_df_pkg::KindGood;
          end else begin
            res.kind = hdlc_df_pkg::KindBad;
          end
        end
        in_frame_d = 1'b1;
        ones_d     = 3'd0;
        pos_d      = 3'd0;
        cnt_d      = '0;
        part_d     = 8'd0;
        crc_d      = hdlc_df_pkg::CrcInit;
      end else if (in_frame_q) begin
        if ((ones_q == hdlc_df_pkg::StuffRun) && !bit_i) begin
          // Stuffed zero after five ones is dropped.
          ones_d = 3'd0;
        end else if (bit_i && (ones_q == hdlc_df_pkg::AbortRun)) begin
          // Seventh one in a row aborts the frame.
          if (cnt_q != '0) begin
            res.valid = 1'b1;
            res.kind  = hdlc_df_pkg::KindDiscard;
            res.len   = cnt_q;
          end
          in_frame_d = 1'b0;
          ones_d     = 3'd0;
          pos_d      = 3'd0;
          cnt_d      = '0;
          part_d     = 8'd0;
          crc_d      = hdlc_df_pkg::CrcInit;
        end else begin
          ones_d = bit_i ? ones_q + 3'd1 : 3'd0;
          if (cnt_q != hdlc_df_pkg::MaxCount) begin
            if (pos_q == 3'd7) begin
              res.valid = 1'b1;
              res.kind  = hdlc_df_pkg::KindData;
              res.data  = part_new;
              pos_d     = 3'd0;
              part_d    = 8'd0;
              cnt_d     = cnt_q + 1'b1;
              crc_d     = hdlc_df_pkg::crc_byte(crc_q, part_new);
            end else begin
              pos_d  = pos_q + 3'd1;
              part_d = part_new;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= 8'd0;
      in_frame_q <= 1'b0;
      ones_q     <= 3'd0;
      pos_q      <= 3'd0;
      cnt_q      <= '0;
      part_q     <= 8'd0;
      crc_q      <= hdlc_df_pkg::CrcInit;
    end else begin
      win_q      <= win_d;
      in_frame_q <= in_frame_d;
      ones_q     <= ones_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      part_q     <= part_d;
      crc_q      <= crc_d;
    end
  end

  assign res_o = res;

  `HDLC_DF_ASSERT(a_hunt_clear,
      !in_frame_q |-> (cnt_q == '0) && (pos_q == 3'd0) && (part_q == 8'd0),
      "Byte assembly state is not clear while hunting.")
  `HDLC_DF_ASSERT(a_byte_counts,
      res.valid && (res.kind == hdlc_df_pkg::KindData) |=>
        cnt_q == hdlc_df_pkg::LenW'($past(cnt_q) + 1'b1),
      "A data byte item did not advance the byte count.")
  `HDLC_DF_ASSERT(a_count_limit,
      cnt_q <= hdlc_df_pkg::MaxCount,
      "Byte count ran past the maximum frame length.")

endmodule

// ===== hw/rtl/hdlc_bit_deframer_fcs16_core.sv =====
// HDLC bit deframer with FCS-16 check: input stage, deframer and result register.
// Usage:
//   The input channel (in_valid_i, in_ready_o, bit_in_i) takes one received bit
//   per item. The output channel (out_valid_o, out_ready_i) delivers at most one
//   item per input bit: a data byte (LSB first on the line), a frame end with good
//   or bad FCS, or a discard marker for a short or aborted frame.
//   The configuration channel (cfg_valid_i, cfg_ready_o, min_frame_bytes_i) sets
//   the minimum frame length; it is always ready and is meant to be written idle.
// Pipeline and throughput:
//   A bit is held in the input register and its result, if any, is then valid in
//   the result register. One bit is accepted per clock cycle unless the output
//   stalls; the deframer state updates in a single pass, with the byte-wide CRC
//   step done in the cycle a byte completes.
// Reset:
//   Reset empties both registers, returns the deframer to flag hunting and sets
//   the minimum frame length to six bytes.
// Stalls:
//   While a result waits and out_ready_i is low, the deframer holds its state and
//   the input register keeps one more bit, after which in_ready_o falls.
module hdlc_bit_deframer_fcs16_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         bit_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   result_kind_o,
  output logic [7:0]                   data_byte_o,
  output logic [hdlc_df_pkg::LenW-1:0] frame_length_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   min_frame_bytes_i
);

  logic                 stage_valid;
  logic                 stage_bit;
  logic                 out_free;
  logic                 take;
  logic [7:0]           min_frame_q, min_frame_d;
  logic                 out_valid_q, out_valid_d;
  hdlc_df_pkg::result_t out_q, out_d;
  hdlc_df_pkg::result_t res;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = stage_valid && out_free;

  hdlc_df_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .bit_in_i   (bit_in_i),
    .take_i     (take),
    .valid_o    (stage_valid),
    .bit_o      (stage_bit)
  );

  hdlc_df_proc u_proc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (take),
    .bit_i       (stage_bit),
    .min_frame_i (min_frame_q),
    .res_o       (res)
  );

  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_frame_d = min_frame_q;
    if (cfg_valid_i) begin
      min_frame_d = min_frame_bytes_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      out_valid_d = res.valid;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_frame_q <= hdlc_df_pkg::MinFrameRst;
      out_valid_q <= 1'b0;
    end else begin
      min_frame_q <= min_frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign data_byte_o    = out_q.data;
  assign frame_length_o = out_q.len;

endmodule
